/* src/gesp_pkg.sv */
// Package for the Gray encoder step positioner: operation codes, register
// indexes, reset constants and the item and result types.
// Depends on nothing; the track, drive and core files and the testbench import it.
`default_nettype none

package gesp_pkg;

    // Operation codes of an input transaction
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_ZERO   = 2'd1;
    localparam logic [1:0] OP_GOTO   = 2'd2;
    localparam logic [1:0] OP_MANUAL = 2'd3;

    // Configuration register indexes
    localparam logic REG_HALF_PERIOD  = 1'b0;
    localparam logic REG_TARGET_LIMIT = 1'b1;

    localparam int CFG_DATA_W = 16;

    // Reset values
    localparam logic [31:0] POSITION_RESET    = 32'd7086;
    localparam logic [7:0]  HALF_PERIOD_RESET = 8'd15;
    localparam logic [15:0] LIMIT_RESET       = 16'd11000;
    localparam logic [7:0]  CODE_INVERT       = 8'h7F;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  encoder_code;
        logic [15:0] target;
        logic        manual_on;
        logic        manual_dir;
    } item_t;

    typedef struct packed {
        logic               step_pulse;
        logic               direction;
        logic               drive_enable;
        logic signed [31:0] position;
        logic [7:0]         angle;
        logic signed [39:0] fine_position;
        logic               arrived;
    } result_t;

    // Drive outputs after one transaction
    typedef struct packed {
        logic step_pulse;
        logic direction;
        logic drive_enable;
        logic arrived;
    } drive_res_t;

    // Current drive state, for checking
    typedef struct packed {
        logic going;
        logic manual;
        logic pulse;
    } drive_stat_t;

endpackage : gesp_pkg

`default_nettype wire

/* src/gesp_item_if.sv */
// Input channel of the positioner: valid/ready handshake with one item.
// Depends on nothing.
`default_nettype none

interface gesp_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [7:0]  encoder_code;
    logic [15:0] target;
    logic        manual_on;
    logic        manual_dir;

    modport source (
        output valid, operation, encoder_code, target, manual_on, manual_dir,
        input  ready
    );

    modport sink (
        input  valid, operation, encoder_code, target, manual_on, manual_dir,
        output ready
    );
endinterface : gesp_item_if

`default_nettype wire

/* src/gesp_result_if.sv */
// Result channel of the positioner: valid/ready handshake with one result.
// Depends on nothing.
`default_nettype none

interface gesp_result_if;
    logic               valid;
    logic               ready;
    logic               step_pulse;
    logic               direction;
    logic               drive_enable;
    logic signed [31:0] position;
    logic [7:0]         angle;
    logic signed [39:0] fine_position;
    logic               arrived;

    modport source (
        output valid, step_pulse, direction, drive_enable, position, angle,
               fine_position, arrived,
        input  ready
    );

    modport sink (
        input  valid, step_pulse, direction, drive_enable, position, angle,
               fine_position, arrived,
        output ready
    );
endinterface : gesp_result_if

`default_nettype wire

/* src/gesp_track.sv */
// Angle decode and multi-turn position tracking.
// Depends on gesp_pkg.
`default_nettype none

module gesp_track (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          advance,
    input  wire gesp_pkg::item_t item,
    output logic [31:0]        pos_next,
    output logic [7:0]         angle_next
);
    import gesp_pkg::*;

    logic [31:0] position_reg;
    logic [7:0]  last_angle_reg;
    logic        primed_reg;
    logic        primed_next;
    logic [7:0]  gray;
    logic [7:0]  bin;
    logic [7:0]  delta;

    // Invert the low seven code bits and take the Gray inverse by prefix xor
    always_comb
    begin
        gray = item.encoder_code ^ CODE_INVERT;
        bin  = gray;
        bin  = bin ^ (bin >> 1);
        bin  = bin ^ (bin >> 2);
        bin  = bin ^ (bin >> 4);
    end

    // A tick subtracts the wrapped signed angle delta from the position once primed; a zero clears it
    always_comb
    begin
        delta       = bin - last_angle_reg;
        pos_next    = position_reg;
        angle_next  = last_angle_reg;
        primed_next = primed_reg;
        case (item.operation)
            OP_TICK:
            begin
                if (primed_reg)
                begin
                    pos_next = position_reg - {{24{delta[7]}}, delta};
                end
                angle_next  = bin;
                primed_next = 1'b1;
            end
            OP_ZERO:
            begin
                pos_next = '0;
            end
            default:
            begin
                pos_next = position_reg;
            end
        endcase
    end

    // Commit on each processed transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg   <= POSITION_RESET;
            last_angle_reg <= '0;
            primed_reg     <= 1'b0;
        end
        else if (advance)
        begin
            position_reg   <= pos_next;
            last_angle_reg <= angle_next;
            primed_reg     <= primed_next;
        end
    end

endmodule : gesp_track

`default_nettype wire

/* src/gesp_drive.sv */
// Motion control: goal, go and manual modes, direction and step divider.
// Depends on gesp_pkg.
`default_nettype none

module gesp_drive (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            advance,
    input  wire gesp_pkg::item_t item,
    input  wire logic [7:0]      half_period,
    input  wire logic [15:0]     target_limit,
    input  wire logic [31:0]     pos_next,
    output gesp_pkg::drive_res_t res_next,
    output gesp_pkg::drive_stat_t stat
);
    import gesp_pkg::*;

    logic [15:0] goal_reg,    goal_next;
    logic        going_reg,   going_next;
    logic        manual_reg,  manual_next;
    logic        dir_reg,     dir_next;
    logic [7:0]  divider_reg, divider_next;
    logic        pulse_reg,   pulse_next;
    logic [15:0] clamped;
    logic [31:0] diff;
    logic        steer_dir;

    // Saturate the requested target at the limit
    assign clamped = (item.target > target_limit) ? target_limit : item.target;

    // Direction toward the goal in effect after this transaction
    always_comb
    begin
        diff      = {16'd0, goal_next} - pos_next;
        steer_dir = !((diff != '0) && !diff[31]);
    end

    always_comb
    begin
        goal_next    = goal_reg;
        going_next   = going_reg;
        manual_next  = manual_reg;
        dir_next     = dir_reg;
        divider_next = divider_reg;
        pulse_next   = pulse_reg;
        case (item.operation)
            OP_TICK:
            begin
                if (going_reg)
                begin
                    dir_next = steer_dir;
                    if (pos_next == {16'd0, goal_reg})
                    begin
                        going_next = 1'b0;
                    end
                end
                if (divider_reg >= half_period)
                begin
                    divider_next = '0;
                    if (going_next || manual_reg)
                    begin
                        pulse_next = !pulse_reg;
                    end
                end
                else
                begin
                    divider_next = divider_reg + 8'd1;
                end
            end
            OP_GOTO:
            begin
                goal_next = clamped;
                if (pos_next != {16'd0, clamped})
                begin
                    going_next  = 1'b1;
                    manual_next = 1'b0;
                    dir_next    = steer_dir;
                end
            end
            OP_MANUAL:
            begin
                if (item.manual_on)
                begin
                    manual_next = 1'b1;
                    dir_next    = item.manual_dir;
                    going_next  = 1'b0;
                end
                else
                begin
                    manual_next = 1'b0;
                end
            end
            default:
            begin
                goal_next = goal_reg;
            end
        endcase
    end

    always_comb
    begin
        res_next.step_pulse   = pulse_next;
        res_next.direction    = dir_next;
        res_next.drive_enable = going_next || manual_next;
        res_next.arrived      = (pos_next == {16'd0, goal_next});
        stat.going            = going_reg;
        stat.manual           = manual_reg;
        stat.pulse            = pulse_reg;
    end

    // Commit on each processed transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_reg    <= '0;
            going_reg   <= 1'b0;
            manual_reg  <= 1'b0;
            dir_reg     <= 1'b0;
            divider_reg <= '0;
            pulse_reg   <= 1'b0;
        end
        else if (advance)
        begin
            goal_reg    <= goal_next;
            going_reg   <= going_next;
            manual_reg  <= manual_next;
            dir_reg     <= dir_next;
            divider_reg <= divider_next;
            pulse_reg   <= pulse_next;
        end
    end

endmodule : gesp_drive

`default_nettype wire

/* src/gray_encoder_step_positioner_core.sv */
// Top level of the Gray encoder step positioner: input register, config
// registers, result register. Depends on gesp_pkg, gesp_item_if,
// gesp_result_if, gesp_track and gesp_drive.
//
//  Channel   Direction  Handshake          Contents
//  item      in         valid/ready        operation, code, target, manual
//  result    out        valid/ready        pulse, direction, position, ...
//  cfg       in         cfg_wen only       half period, target limit
//
// An accepted transaction is held in the input register; when it moves on,
// the state is updated and the result register loaded, and one transaction
// is taken every cycle while the result side does not stall.
// The result register is the only stall point: while it is full and not
// taken, the input register holds and item.ready drops once it is full.
// Reset is asynchronous, active low, and leaves both stages empty.
`default_nettype none

module gray_encoder_step_positioner_core (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    gesp_item_if.sink                         item,
    gesp_result_if.source                     result,
    input  wire logic                         cfg_wen,
    input  wire logic                         cfg_index,
    input  wire logic [gesp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import gesp_pkg::*;

    logic        s1_valid_reg;
    item_t       s1_reg;
    logic        out_valid_reg;
    result_t     result_reg;
    logic [7:0]  half_period_reg;
    logic [15:0] target_limit_reg;
    logic        out_free;
    logic        s1_move;
    logic        item_fire;
    logic [31:0] pos_next;
    logic [7:0]  angle_next;
    drive_res_t  drv_res;
    drive_stat_t drv_stat;

    // Handshake control
    assign out_free   = !out_valid_reg || result.ready;
    assign s1_move    = s1_valid_reg && out_free;
    assign item.ready = !s1_valid_reg || out_free;
    assign item_fire  = item.valid && item.ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg  <= HALF_PERIOD_RESET;
            target_limit_reg <= LIMIT_RESET;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                REG_HALF_PERIOD:  half_period_reg  <= cfg_wdata[7:0];
                REG_TARGET_LIMIT: target_limit_reg <= cfg_wdata[15:0];
                default:          half_period_reg  <= half_period_reg;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            s1_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_fire)
        begin
            s1_reg.operation    <= item.operation;
            s1_reg.encoder_code <= item.encoder_code;
            s1_reg.target       <= item.target;
            s1_reg.manual_on    <= item.manual_on;
            s1_reg.manual_dir   <= item.manual_dir;
        end
    end

    gesp_track u_track (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (s1_move),
        .item       (s1_reg),
        .pos_next   (pos_next),
        .angle_next (angle_next)
    );

    gesp_drive u_drive (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (s1_move),
        .item         (s1_reg),
        .half_period  (half_period_reg),
        .target_limit (target_limit_reg),
        .pos_next     (pos_next),
        .res_next     (drv_res),
        .stat         (drv_stat)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            result_reg.step_pulse    <= drv_res.step_pulse;
            result_reg.direction     <= drv_res.direction;
            result_reg.drive_enable  <= drv_res.drive_enable;
            result_reg.position      <= pos_next;
            result_reg.angle         <= angle_next;
            result_reg.fine_position <= {pos_next, angle_next};
            result_reg.arrived       <= drv_res.arrived;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.step_pulse    = result_reg.step_pulse;
    assign result.direction     = result_reg.direction;
    assign result.drive_enable  = result_reg.drive_enable;
    assign result.position      = result_reg.position;
    assign result.angle         = result_reg.angle;
    assign result.fine_position = result_reg.fine_position;
    assign result.arrived       = result_reg.arrived;

    // Go and manual modes never run together
    a_mode_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(drv_stat.going && drv_stat.manual))
        else $error("going and manual run both active");

    // Only a tick may change the step pulse
    a_pulse_tick_only: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_move && (s1_reg.operation != OP_TICK))
        |=> (result_reg.step_pulse == $past(drv_stat.pulse)))
        else $error("step pulse changed on a non-tick transaction");

    // An accepted transaction always lands in the input register
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        item_fire |=> s1_valid_reg)
        else $error("accepted transaction lost");

    // A result leaves only when taken
    a_result_taken: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid_reg) |-> $past(result.ready))
        else $error("result dropped without handshake");

endmodule : gray_encoder_step_positioner_core

`default_nettype wire

/* dv/gray_encoder_step_positioner_core_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for gray_encoder_step_positioner_core: a directed table,
// then closed-loop random encoder motion and commands under several register settings.
// Depends on gesp_pkg, gesp_item_if, gesp_result_if and the core RTL.

module gray_encoder_step_positioner_core_tb;
    import gesp_pkg::*;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int LONG_HOLD     = 80;
    localparam int RANDOM_ITEMS  = 145;
    localparam int SHOWN_ERRORS  = 10;

    typedef struct {
        item_t   stim;
        bit      typed;
        result_t want;
    } row_t;

    logic clk;
    logic rst_n;
    logic cfg_wen;
    logic cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    gesp_item_if   item_ch();
    gesp_result_if result_ch();

    gray_encoder_step_positioner_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Shadow of the positioner state and its registers
    logic [31:0] trk_pos;
    logic [7:0]  trk_angle;
    bit          trk_primed;
    logic [15:0] goal_pos;
    bit          is_going;
    bit          in_manual;
    logic        drive_dir;
    logic [7:0]  div_count;
    logic        pulse_q;
    logic [7:0]  cfg_half;
    logic [15:0] cfg_limit;

    // Simulated shaft angle for closed-loop random motion
    logic [7:0]  walk_angle;

    result_t predicted_results[$];
    row_t    directed_rows[$];

    int  cycle_count;
    int  mismatch_count;
    int  checked_count;
    int  arrival_count;
    int  sent_count;
    int  setting_count;
    bit  idling_on;
    bit  hold_request;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Point the drive toward the goal
    function automatic void set_heading();
        logic [31:0] gap;
        gap = {16'd0, goal_pos} - trk_pos;
        drive_dir = (gap != 32'd0 && !gap[31]) ? 1'b0 : 1'b1;
    endfunction

    // Advance the shadow state by one transaction and return its result
    function automatic result_t predict_positioner(item_t it);
        result_t     r;
        logic [7:0]  g;
        logic [7:0]  ang;
        logic [7:0]  delta;
        case (it.operation)
            OP_TICK:
            begin
                g = it.encoder_code ^ CODE_INVERT;
                ang[7] = g[7];
                for (int i = 6; i >= 0; i--)
                    ang[i] = ang[i + 1] ^ g[i];
                if (!trk_primed)
                begin
                    trk_angle  = ang;
                    trk_primed = 1'b1;
                end
                else if (ang != trk_angle)
                begin
                    delta     = ang - trk_angle;
                    trk_pos   = trk_pos - {{24{delta[7]}}, delta};
                    trk_angle = ang;
                end
                if (is_going)
                begin
                    set_heading();
                    if (trk_pos == {16'd0, goal_pos})
                        is_going = 1'b0;
                end
                if (div_count >= cfg_half)
                begin
                    div_count = 8'd0;
                    if (is_going || in_manual)
                        pulse_q = ~pulse_q;
                end
                else
                    div_count = div_count + 8'd1;
            end
            OP_ZERO:
                trk_pos = 32'd0;
            OP_GOTO:
            begin
                goal_pos = (it.target > cfg_limit) ? cfg_limit : it.target;
                if (trk_pos != {16'd0, goal_pos})
                begin
                    is_going  = 1'b1;
                    in_manual = 1'b0;
                    set_heading();
                end
            end
            default:
            begin
                if (it.manual_on)
                begin
                    in_manual = 1'b1;
                    drive_dir = it.manual_dir;
                    is_going  = 1'b0;
                end
                else
                    in_manual = 1'b0;
            end
        endcase
        r.step_pulse    = pulse_q;
        r.direction     = drive_dir;
        r.drive_enable  = is_going || in_manual;
        r.position      = trk_pos;
        r.angle         = trk_angle;
        r.fine_position = {trk_pos, trk_angle};
        r.arrived       = (trk_pos == {16'd0, goal_pos});
        return r;
    endfunction

    // Mostly smooth encoder motion that follows the drive, plus commands and noise
    function automatic item_t random_item();
        item_t it;
        int    pick;
        int    stride;
        it.operation    = OP_TICK;
        it.encoder_code = 8'($urandom);
        it.target       = 16'($urandom);
        it.manual_on    = 1'($urandom);
        it.manual_dir   = 1'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 70)
        begin
            stride = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : 1;
            if (is_going || in_manual)
                walk_angle = drive_dir ? walk_angle + 8'(stride) : walk_angle - 8'(stride);
            else
                walk_angle = walk_angle + 8'($urandom_range(0, 6)) - 8'd3;
            it.encoder_code = (walk_angle ^ (walk_angle >> 1)) ^ CODE_INVERT;
        end
        else if (pick < 78)
            it.operation = OP_TICK;
        else if (pick < 88)
        begin
            it.operation = OP_GOTO;
            if ($urandom_range(0, 3) != 0)
                it.target = trk_pos[15:0] + 16'($urandom_range(0, 40)) - 16'd20;
        end
        else if (pick < 96)
        begin
            it.operation = OP_MANUAL;
            it.manual_on = ($urandom_range(0, 2) != 0);
        end
        else
            it.operation = OP_ZERO;
        return it;
    endfunction

    // Offer one transaction, wait for acceptance, record its prediction
    task automatic send_item(item_t it, bit typed, result_t want);
        result_t predicted;
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.operation    <= it.operation;
        item_ch.encoder_code <= it.encoder_code;
        item_ch.target       <= it.target;
        item_ch.manual_on    <= it.manual_on;
        item_ch.manual_dir   <= it.manual_dir;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        predicted = predict_positioner(it);
        predicted_results.push_back(typed ? want : predicted);
        sent_count++;
        @(negedge clk);
    endtask

    task automatic run_random(int count);
        for (int n = 0; n < count; n++)
            send_item(random_item(), 1'b0, '0);
        item_ch.valid <= 1'b0;
    endtask

    // Wait until every predicted result has come back and the pipeline is empty
    task automatic settle();
        while (predicted_results.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_register(logic idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge clk);
        cfg_wen   <= 1'b0;
        if (idx == REG_HALF_PERIOD)
            cfg_half = data[7:0];
        else
            cfg_limit = data;
    endtask

    task automatic add_row(logic [1:0] op, logic [7:0] code, logic [15:0] tgt,
                           logic on, logic dr, bit typed, result_t want);
        row_t row;
        row.stim.operation    = op;
        row.stim.encoder_code = code;
        row.stim.target       = tgt;
        row.stim.manual_on    = on;
        row.stim.manual_dir   = dr;
        row.typed             = typed;
        row.want              = want;
        directed_rows.push_back(row);
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_left    = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else if (idling_on && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(1, 11) - 1;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    // Check each result transaction against the oldest prediction
    initial
    begin
        result_t got;
        result_t want;
        forever
        begin
            @(posedge clk);
            if (result_ch.valid && result_ch.ready)
            begin
                got.step_pulse    = result_ch.step_pulse;
                got.direction     = result_ch.direction;
                got.drive_enable  = result_ch.drive_enable;
                got.position      = result_ch.position;
                got.angle         = result_ch.angle;
                got.fine_position = result_ch.fine_position;
                got.arrived       = result_ch.arrived;
                if (got.arrived === 1'b1)
                    arrival_count++;
                if (predicted_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= SHOWN_ERRORS)
                        $display("unexpected result at cycle %0d", cycle_count);
                end
                else
                begin
                    want = predicted_results.pop_front();
                    checked_count++;
                    if (got.step_pulse !== want.step_pulse
                        || got.direction !== want.direction
                        || got.drive_enable !== want.drive_enable
                        || got.position !== want.position
                        || got.angle !== want.angle
                        || got.fine_position !== want.fine_position
                        || got.arrived !== want.arrived)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= SHOWN_ERRORS)
                        begin
                            $display("mismatch on result %0d at cycle %0d",
                                     checked_count, cycle_count);
                            $display("  expected pulse=%b dir=%b en=%b pos=%0d ang=%0d fine=%0d arr=%b",
                                     want.step_pulse, want.direction, want.drive_enable,
                                     want.position, want.angle, want.fine_position,
                                     want.arrived);
                            $display("  actual   pulse=%b dir=%b en=%b pos=%0d ang=%0d fine=%0d arr=%b",
                                     got.step_pulse, got.direction, got.drive_enable,
                                     got.position, got.angle, got.fine_position,
                                     got.arrived);
                        end
                    end
                end
            end
        end
    end

    // Watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, predicted_results.size());
        $display("status: fail");
        $finish;
    end

    // Main sequence
    initial
    begin
        result_t at_reset;
        result_t at_zero;
        int      directed_count;

        rst_n                = 1'b0;
        cfg_wen              = 1'b0;
        cfg_index            = REG_HALF_PERIOD;
        cfg_wdata            = '0;
        item_ch.valid        = 1'b0;
        item_ch.operation    = OP_TICK;
        item_ch.encoder_code = 8'd0;
        item_ch.target       = 16'd0;
        item_ch.manual_on    = 1'b0;
        item_ch.manual_dir   = 1'b0;
        result_ch.ready      = 1'b0;
        mismatch_count       = 0;
        checked_count        = 0;
        arrival_count        = 0;
        sent_count           = 0;
        setting_count        = 1;
        idling_on            = 1'b1;
        hold_request         = 1'b0;
        walk_angle           = 8'd0;

        // Shadow state as after reset
        trk_pos    = POSITION_RESET;
        trk_angle  = 8'd0;
        trk_primed = 1'b0;
        goal_pos   = 16'd0;
        is_going   = 1'b0;
        in_manual  = 1'b0;
        drive_dir  = 1'b0;
        div_count  = 8'd0;
        pulse_q    = 1'b0;
        cfg_half   = HALF_PERIOD_RESET;
        cfg_limit  = LIMIT_RESET;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        at_reset = '{step_pulse: 1'b0, direction: 1'b0, drive_enable: 1'b0,
                     position: 32'sd7086, angle: 8'd0,
                     fine_position: 40'sd1814016, arrived: 1'b0};
        at_zero  = '{step_pulse: 1'b0, direction: 1'b0, drive_enable: 1'b0,
                     position: 32'sd0, angle: 8'd0,
                     fine_position: 40'sd0, arrived: 1'b1};

        // Directed table: reset state, first tick, extremes, every command
        add_row(OP_MANUAL, 8'h00, 16'h0000, 1'b0, 1'b0, 1'b1, at_reset);
        add_row(OP_ZERO,   8'h00, 16'h0000, 1'b0, 1'b0, 1'b1, at_zero);
        add_row(OP_TICK,   8'h7F, 16'h0000, 1'b0, 1'b0, 1'b1, at_zero);
        add_row(OP_TICK,   8'h80, 16'h0000, 1'b0, 1'b0, 1'b0, '0);
        add_row(OP_TICK,   8'hFF, 16'hFFFF, 1'b1, 1'b1, 1'b0, '0);
        add_row(OP_TICK,   8'h00, 16'h0000, 1'b0, 1'b0, 1'b0, '0);
        add_row(OP_GOTO,   8'h00, 16'hFFFF, 1'b0, 1'b0, 1'b0, '0);
        add_row(OP_TICK,   8'h01, 16'h0000, 1'b0, 1'b0, 1'b0, '0);
        add_row(OP_MANUAL, 8'h00, 16'h0000, 1'b1, 1'b1, 1'b0, '0);
        add_row(OP_TICK,   8'h7F, 16'h0000, 1'b0, 1'b0, 1'b0, '0);
        add_row(OP_MANUAL, 8'h00, 16'h0000, 1'b0, 1'b1, 1'b0, '0);
        add_row(OP_ZERO,   8'hFF, 16'hFFFF, 1'b1, 1'b1, 1'b0, '0);
        add_row(OP_GOTO,   8'h00, 16'h0000, 1'b0, 1'b0, 1'b0, '0);
        add_row(OP_GOTO,   8'h00, 16'h0100, 1'b0, 1'b0, 1'b0, '0);
        add_row(OP_GOTO,   8'h00, 16'h0000, 1'b0, 1'b0, 1'b0, '0);
        add_row(OP_TICK,   8'h7F, 16'h0000, 1'b0, 1'b0, 1'b0, '0);
        add_row(OP_MANUAL, 8'h00, 16'h0000, 1'b1, 1'b0, 1'b0, '0);
        add_row(OP_TICK,   8'h7E, 16'h0000, 1'b0, 1'b0, 1'b0, '0);
        add_row(OP_TICK,   8'h7C, 16'h0000, 1'b0, 1'b0, 1'b0, '0);
        add_row(OP_GOTO,   8'h00, 16'h2AD5, 1'b0, 1'b0, 1'b0, '0);
        add_row(OP_TICK,   8'h3F, 16'h0000, 1'b0, 1'b0, 1'b0, '0);
        add_row(OP_MANUAL, 8'h00, 16'h0000, 1'b0, 1'b0, 1'b0, '0);

        foreach (directed_rows[i])
            send_item(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);
        directed_count = sent_count;

        // Reset register values; hold the receiver off so the input backs up
        hold_request = 1'b1;
        run_random(RANDOM_ITEMS);

        // Fastest pulse, every goal saturates to zero; upper data bits are noise
        settle();
        write_register(REG_HALF_PERIOD, {8'($urandom), 8'd0});
        write_register(REG_TARGET_LIMIT, 16'd0);
        setting_count++;
        run_random(RANDOM_ITEMS);

        // Slowest pulse, no saturation
        settle();
        write_register(REG_HALF_PERIOD, 16'h00FF);
        write_register(REG_TARGET_LIMIT, 16'hFFFF);
        setting_count++;
        run_random(RANDOM_ITEMS);

        // Mid settings, back-to-back traffic on both sides
        settle();
        idling_on = 1'b0;
        write_register(REG_HALF_PERIOD, 16'd3);
        write_register(REG_TARGET_LIMIT, 16'($urandom_range(200, 12000)));
        setting_count++;
        run_random(RANDOM_ITEMS);

        settle();
        $display("covered %0d directed and %0d random transactions over %0d register settings",
                 directed_count, sent_count - directed_count, setting_count);
        $display("%0d results checked, %0d with arrival, %0d mismatches",
                 checked_count, arrival_count, mismatch_count);
        if (mismatch_count == 0 && predicted_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
